// ===== sv/amv_pkg.sv =====
// Shared types and constants for the axis-blocking mover.
package amv_pkg;

   localparam int COORD_BITS = 16;
   localparam int ID_BITS    = 16;
   localparam int SIZE_BITS  = 15;
   localparam int EXT_BITS   = COORD_BITS + 3;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_MOVE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_REDUCE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic reduce;
      logic commit;
   } ctl_type;

endpackage

// ===== sv/amv_ctrl.sv =====
// Controller state machine: sequences load, evaluate, reduce and commit.
module amv_ctrl
   import amv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output ctl_type ctl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fire;

   assign fire = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_COMMIT;
         ST_COMMIT: if (fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         ST_EVAL:   ctl.eval = 1'b1;
         ST_REDUCE: ctl.reduce = 1'b1;
         ST_COMMIT: begin
            ctl.commit = fire;
            if (fire) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/amv_cell.sv =====
// One collider cell: strict overlap tests of the entity box against one stored box.
module amv_cell
   import amv_pkg::*;
(
   input  logic                        clock,
   input  logic                        eval,
   input  logic                        box_valid,
   input  logic [ID_BITS-1:0]          box_id,
   input  logic signed [COORD_BITS-1:0] box_x,
   input  logic signed [COORD_BITS-1:0] box_y,
   input  logic [SIZE_BITS-1:0]        box_w,
   input  logic [SIZE_BITS-1:0]        box_h,
   input  logic [ID_BITS-1:0]          ent_id,
   input  logic signed [COORD_BITS-1:0] ent_x,
   input  logic signed [COORD_BITS-1:0] ent_y,
   input  logic signed [COORD_BITS-1:0] ent_vx,
   input  logic signed [COORD_BITS-1:0] ent_vy,
   input  logic [SIZE_BITS-1:0]        ent_w,
   input  logic [SIZE_BITS-1:0]        ent_h,
   output logic                        hit_x,
   output logic                        hit_y
);

   localparam int SE = EXT_BITS - COORD_BITS;
   localparam int ZE = EXT_BITS - SIZE_BITS;

   logic signed [EXT_BITS-1:0] px, py, vx, vy, aw, ah, bx, by, bw, bh;
   logic signed [EXT_BITS-1:0] mx, my, b_right, b_top;
   logic                       live, ov_y, ov_x;
   logic                       hit_x_ff, hit_x_in, hit_y_ff, hit_y_in;

   always_comb begin
      px = {{SE{ent_x[COORD_BITS-1]}}, ent_x};
      py = {{SE{ent_y[COORD_BITS-1]}}, ent_y};
      vx = {{SE{ent_vx[COORD_BITS-1]}}, ent_vx};
      vy = {{SE{ent_vy[COORD_BITS-1]}}, ent_vy};
      bx = {{SE{box_x[COORD_BITS-1]}}, box_x};
      by = {{SE{box_y[COORD_BITS-1]}}, box_y};
      aw = {{ZE{1'b0}}, ent_w};
      ah = {{ZE{1'b0}}, ent_h};
      bw = {{ZE{1'b0}}, box_w};
      bh = {{ZE{1'b0}}, box_h};
      mx = px + vx;
      my = py + vy;
      b_right = bx + bw;
      b_top   = by + bh;
      live = box_valid && (box_id != ent_id);
      // y-only shift, then x-only shift
      ov_y = (px + aw > bx) && (px < b_right) && (my + ah > by) && (my < b_top);
      ov_x = (mx + aw > bx) && (mx < b_right) && (py + ah > by) && (py < b_top);
      hit_y_in = eval ? (live && ov_y) : hit_y_ff;
      hit_x_in = eval ? (live && ov_x) : hit_x_ff;
   end

   always_ff @(posedge clock) begin
      hit_x_ff <= hit_x_in;
      hit_y_ff <= hit_y_in;
   end

   assign hit_x = hit_x_ff;
   assign hit_y = hit_y_ff;

endmodule

// ===== sv/amv_datapath.sv =====
// Datapath: collider table, cell array, hit reduction, table update and result register.
module amv_datapath
   import amv_pkg::*;
#(
   parameter int MAX_COLLIDERS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_type                      ctl,
   input  logic [1:0]                   req_cmd,
   input  logic [ID_BITS-1:0]           req_entity_id,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_vel_x,
   input  logic signed [COORD_BITS-1:0] req_vel_y,
   input  logic [SIZE_BITS-1:0]         req_size_w,
   input  logic [SIZE_BITS-1:0]         req_size_h,
   input  logic                         req_has_size,
   input  logic                         req_is_collidable,
   output logic signed [COORD_BITS-1:0] rsp_new_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_new_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_new_vel_x,
   output logic signed [COORD_BITS-1:0] rsp_new_vel_y,
   output logic                         rsp_status
);

   localparam int N     = MAX_COLLIDERS;
   localparam int SlotW = (N > 1) ? $clog2(N) : 1;

   // latched beat
   cmd_type                      cmd_ff;
   logic [ID_BITS-1:0]           eid_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, vx_ff, vy_ff;
   logic [SIZE_BITS-1:0]         w_ff, h_ff;
   logic                         hs_ff;
   logic                         coll_ff;
   logic [SIZE_BITS-1:0]         ent_w, ent_h;

   // table
   logic                         box_valid_ff [N];
   logic [ID_BITS-1:0]           box_id_ff [N];
   logic signed [COORD_BITS-1:0] box_x_ff [N];
   logic signed [COORD_BITS-1:0] box_y_ff [N];
   logic [SIZE_BITS-1:0]         box_w_ff [N];
   logic [SIZE_BITS-1:0]         box_h_ff [N];

   logic [N-1:0] hit_x, hit_y;

   logic             blk_x_ff, blk_x_in, blk_y_ff, blk_y_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic             full_ff, full_in;

   logic signed [COORD_BITS-1:0] vx_eff, vy_eff, nx, ny;

   logic signed [COORD_BITS-1:0] out_px_ff, out_py_ff, out_vx_ff, out_vy_ff;
   logic                         out_st_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= cmd_type'(req_cmd);
         eid_ff  <= req_entity_id;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         vx_ff   <= req_vel_x;
         vy_ff   <= req_vel_y;
         w_ff    <= req_size_w;
         h_ff    <= req_size_h;
         hs_ff   <= req_has_size;
         coll_ff <= req_is_collidable;
      end
   end

   // moving entity without a size has a zero box
   assign ent_w = hs_ff ? w_ff : '0;
   assign ent_h = hs_ff ? h_ff : '0;

   for (genvar g = 0; g < N; g++) begin : g_cell
      amv_cell u_cell (
         .clock     (clock),
         .eval      (ctl.eval),
         .box_valid (box_valid_ff[g]),
         .box_id    (box_id_ff[g]),
         .box_x     (box_x_ff[g]),
         .box_y     (box_y_ff[g]),
         .box_w     (box_w_ff[g]),
         .box_h     (box_h_ff[g]),
         .ent_id    (eid_ff),
         .ent_x     (px_ff),
         .ent_y     (py_ff),
         .ent_vx    (vx_ff),
         .ent_vy    (vy_ff),
         .ent_w     (ent_w),
         .ent_h     (ent_h),
         .hit_x     (hit_x[g]),
         .hit_y     (hit_y[g])
      );
   end

   // add lands in the lowest free slot
   always_comb begin
      slot_in = '0;
      full_in = 1'b1;
      for (int i = N - 1; i >= 0; i--) begin
         if (!box_valid_ff[i]) begin
            slot_in = SlotW'(i);
            full_in = 1'b0;
         end
      end
      blk_x_in = coll_ff && (|hit_x);
      blk_y_in = coll_ff && (|hit_y);
   end

   always_ff @(posedge clock) begin
      if (ctl.reduce) begin
         slot_ff  <= slot_in;
         full_ff  <= full_in;
         blk_x_ff <= blk_x_in;
         blk_y_ff <= blk_y_in;
      end
   end

   always_comb begin
      vx_eff = blk_x_ff ? '0 : vx_ff;
      vy_eff = blk_y_ff ? '0 : vy_ff;
      nx     = px_ff + vx_eff;
      ny     = py_ff + vy_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) box_valid_ff[i] <= 1'b0;
      end else if (ctl.commit) begin
         for (int i = 0; i < N; i++) begin
            case (cmd_ff)
               CMD_CLEAR: box_valid_ff[i] <= 1'b0;
               CMD_ADD:   if (!full_ff && slot_ff == SlotW'(i)) box_valid_ff[i] <= 1'b1;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         for (int i = 0; i < N; i++) begin
            case (cmd_ff)
               CMD_ADD: begin
                  if (!full_ff && slot_ff == SlotW'(i)) begin
                     box_id_ff[i] <= eid_ff;
                     box_x_ff[i]  <= px_ff;
                     box_y_ff[i]  <= py_ff;
                     box_w_ff[i]  <= w_ff;
                     box_h_ff[i]  <= h_ff;
                  end
               end
               CMD_MOVE: begin
                  if (box_valid_ff[i] && box_id_ff[i] == eid_ff) begin
                     box_x_ff[i] <= nx;
                     box_y_ff[i] <= ny;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // size on add is stored raw, not masked by has_size
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         out_px_ff <= '0;
         out_py_ff <= '0;
         out_vx_ff <= '0;
         out_vy_ff <= '0;
         out_st_ff <= 1'b0;
         case (cmd_ff)
            CMD_ADD: out_st_ff <= full_ff;
            CMD_MOVE: begin
               out_px_ff <= nx;
               out_py_ff <= ny;
               out_vx_ff <= vx_eff;
               out_vy_ff <= vy_eff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_new_pos_x = out_px_ff;
   assign rsp_new_pos_y = out_py_ff;
   assign rsp_new_vel_x = out_vx_ff;
   assign rsp_new_vel_y = out_vy_ff;
   assign rsp_status    = out_st_ff;

endmodule

// ===== sv/aabb_axis_blocking_mover_top.sv =====
// Top level of the axis-blocking mover: controller plus datapath.
// Each command beat goes through these steps from acceptance to a registered result:
// load, an evaluate step in which every collider cell runs its two overlap tests in
// parallel, a reduce step that ORs the hits and finds the free slot, and a commit that
// updates the table and loads the result register. A new beat is taken while
// the previous result waits; commit waits only while a result is still held.
// Add with has_size low still stores size_w/size_h as given; has_size only
// masks the moving entity's size.
module aabb_axis_blocking_mover_top
   import amv_pkg::*;
#(
   parameter int MAX_COLLIDERS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [ID_BITS-1:0]           req_entity_id,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_vel_x,
   input  logic signed [COORD_BITS-1:0] req_vel_y,
   input  logic [SIZE_BITS-1:0]         req_size_w,
   input  logic [SIZE_BITS-1:0]         req_size_h,
   input  logic                         req_has_size,
   input  logic                         req_is_collidable,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_new_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_new_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_new_vel_x,
   output logic signed [COORD_BITS-1:0] rsp_new_vel_y,
   output logic                         rsp_status
);

   ctl_type ctl;

   amv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   amv_datapath #(
      .MAX_COLLIDERS (MAX_COLLIDERS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .req_cmd           (req_cmd),
      .req_entity_id     (req_entity_id),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_vel_x         (req_vel_x),
      .req_vel_y         (req_vel_y),
      .req_size_w        (req_size_w),
      .req_size_h        (req_size_h),
      .req_has_size      (req_has_size),
      .req_is_collidable (req_is_collidable),
      .rsp_new_pos_x     (rsp_new_pos_x),
      .rsp_new_pos_y     (rsp_new_pos_y),
      .rsp_new_vel_x     (rsp_new_vel_x),
      .rsp_new_vel_y     (rsp_new_vel_y),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== dv/amv_mover_checker.sv =====
// Checker for the axis-blocking mover: keeps a shadow collider table, predicts and compares.
module amv_mover_checker
   import amv_pkg::*;
#(
   parameter int MAX_COLLIDERS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [ID_BITS-1:0]           req_entity_id,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_vel_x,
   input  logic signed [COORD_BITS-1:0] req_vel_y,
   input  logic [SIZE_BITS-1:0]         req_size_w,
   input  logic [SIZE_BITS-1:0]         req_size_h,
   input  logic                         req_has_size,
   input  logic                         req_is_collidable,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [COORD_BITS-1:0] rsp_new_pos_x,
   input  logic signed [COORD_BITS-1:0] rsp_new_pos_y,
   input  logic signed [COORD_BITS-1:0] rsp_new_vel_x,
   input  logic signed [COORD_BITS-1:0] rsp_new_vel_y,
   input  logic                         rsp_status,
   output int unsigned                  error_count,
   output int unsigned                  outstanding,
   output int unsigned                  blocked_x_count,
   output int unsigned                  blocked_y_count,
   output int unsigned                  dropped_count
);

   typedef struct packed {
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] vel_x;
      logic [COORD_BITS-1:0] vel_y;
      logic                  status;
   } mover_result_type;

   logic                         slot_used [MAX_COLLIDERS];
   logic [ID_BITS-1:0]           slot_id   [MAX_COLLIDERS];
   logic signed [COORD_BITS-1:0] slot_x    [MAX_COLLIDERS];
   logic signed [COORD_BITS-1:0] slot_y    [MAX_COLLIDERS];
   logic [SIZE_BITS-1:0]         slot_w    [MAX_COLLIDERS];
   logic [SIZE_BITS-1:0]         slot_h    [MAX_COLLIDERS];
   mover_result_type             pending_results[$];
   int unsigned                  mismatches;
   int unsigned                  result_index;

   // strict bounds, full width
   function automatic bit boxes_overlap(
      input longint ax, ay, aw, ah,
      input longint bx, by, bw, bh
   );
      return (ax + aw > bx) && (ax < bx + bw) && (ay + ah > by) && (ay < by + bh);
   endfunction

   function automatic mover_result_type predict_mover_result(
      input cmd_type                      cmd,
      input logic [ID_BITS-1:0]           id,
      input logic signed [COORD_BITS-1:0] px, py, vx, vy,
      input logic [SIZE_BITS-1:0]         sw, sh,
      input logic                         has_size, collidable
   );
      mover_result_type             r;
      longint                       ex, ey, dx, dy, ew, eh;
      logic signed [COORD_BITS-1:0] nx, ny;
      int                           free_slot;
      int                           i;
      r = '0;
      case (cmd)
         CMD_CLEAR: begin
            for (i = 0; i < MAX_COLLIDERS; i++) slot_used[i] = 1'b0;
         end
         CMD_ADD: begin
            free_slot = -1;
            for (i = MAX_COLLIDERS - 1; i >= 0; i--) begin
               if (!slot_used[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               r.status = 1'b1;
            end else begin
               slot_used[free_slot] = 1'b1;
               slot_id[free_slot]   = id;
               slot_x[free_slot]    = px;
               slot_y[free_slot]    = py;
               slot_w[free_slot]    = sw;
               slot_h[free_slot]    = sh;
            end
         end
         CMD_MOVE: begin
            ex = px;
            ey = py;
            dx = vx;
            dy = vy;
            ew = has_size ? sw : 0;
            eh = has_size ? sh : 0;
            if (collidable) begin
               for (i = 0; i < MAX_COLLIDERS; i++) begin
                  if (slot_used[i] && slot_id[i] != id) begin
                     if (boxes_overlap(ex, ey + dy, ew, eh,
                                       slot_x[i], slot_y[i], slot_w[i], slot_h[i]))
                        dy = 0;
                     if (boxes_overlap(ex + dx, ey, ew, eh,
                                       slot_x[i], slot_y[i], slot_w[i], slot_h[i]))
                        dx = 0;
                  end
               end
            end
            nx = COORD_BITS'(ex + dx);
            ny = COORD_BITS'(ey + dy);
            for (i = 0; i < MAX_COLLIDERS; i++) begin
               if (slot_used[i] && slot_id[i] == id) begin
                  slot_x[i] = nx;
                  slot_y[i] = ny;
               end
            end
            r.pos_x = nx;
            r.pos_y = ny;
            r.vel_x = COORD_BITS'(dx);
            r.vel_y = COORD_BITS'(dy);
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      mover_result_type want;
      mover_result_type head;
      mover_result_type got;
      int               i;
      if (reset) begin
         for (i = 0; i < MAX_COLLIDERS; i++) slot_used[i] = 1'b0;
         pending_results.delete();
         mismatches = 0;
         result_index = 0;
         error_count     <= 0;
         outstanding     <= 0;
         blocked_x_count <= 0;
         blocked_y_count <= 0;
         dropped_count   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            want = predict_mover_result(cmd_type'(req_cmd), req_entity_id,
                                        req_pos_x, req_pos_y, req_vel_x, req_vel_y,
                                        req_size_w, req_size_h,
                                        req_has_size, req_is_collidable);
            pending_results.push_back(want);
            if (cmd_type'(req_cmd) == CMD_MOVE) begin
               if (req_vel_x != 0 && want.vel_x == '0)
                  blocked_x_count <= blocked_x_count + 1;
               if (req_vel_y != 0 && want.vel_y == '0)
                  blocked_y_count <= blocked_y_count + 1;
            end
            if (want.status) dropped_count <= dropped_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.pos_x  = rsp_new_pos_x;
            got.pos_y  = rsp_new_pos_y;
            got.vel_x  = rsp_new_vel_x;
            got.vel_y  = rsp_new_vel_y;
            got.status = rsp_status;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result beat %0d with nothing expected: ",
                            "pos (%0d,%0d) vel (%0d,%0d) st %0b"},
                           result_index, $signed(got.pos_x), $signed(got.pos_y),
                           $signed(got.vel_x), $signed(got.vel_y), got.status);
            end else begin
               head = pending_results.pop_front();
               if (got.pos_x !== head.pos_x || got.pos_y !== head.pos_y ||
                   got.vel_x !== head.vel_x || got.vel_y !== head.vel_y ||
                   got.status !== head.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result beat %0d: expected pos (%0d,%0d) vel (%0d,%0d) ",
                               "st %0b, got pos (%0d,%0d) vel (%0d,%0d) st %0b"},
                              result_index,
                              $signed(head.pos_x), $signed(head.pos_y),
                              $signed(head.vel_x), $signed(head.vel_y), head.status,
                              $signed(got.pos_x), $signed(got.pos_y),
                              $signed(got.vel_x), $signed(got.vel_y), got.status);
               end
            end
            result_index++;
         end
         error_count <= mismatches;
         outstanding <= pending_results.size();
      end
   end

endmodule

// ===== dv/aabb_axis_blocking_mover_top_tb.sv =====
// Testbench top for the axis-blocking mover: command stimulus, handshake pressure and verdict.
module aabb_axis_blocking_mover_top_tb;
   import amv_pkg::*;

   localparam int MAX_COLLIDERS = 16;
   localparam int RANDOM_BEATS  = 1750;
   localparam int CYCLE_LIMIT   = 500_000;

   logic                         clock             = 1'b0;
   logic                         reset             = 1'b1;
   logic                         req_valid         = 1'b0;
   logic [1:0]                   req_cmd           = CMD_NOP;
   logic [ID_BITS-1:0]           req_entity_id     = '0;
   logic signed [COORD_BITS-1:0] req_pos_x         = '0;
   logic signed [COORD_BITS-1:0] req_pos_y         = '0;
   logic signed [COORD_BITS-1:0] req_vel_x         = '0;
   logic signed [COORD_BITS-1:0] req_vel_y         = '0;
   logic [SIZE_BITS-1:0]         req_size_w        = '0;
   logic [SIZE_BITS-1:0]         req_size_h        = '0;
   logic                         req_has_size      = 1'b0;
   logic                         req_is_collidable = 1'b0;
   logic                         rsp_stall         = 1'b0;
   logic                         req_stall;
   logic                         rsp_valid;
   logic signed [COORD_BITS-1:0] rsp_new_pos_x;
   logic signed [COORD_BITS-1:0] rsp_new_pos_y;
   logic signed [COORD_BITS-1:0] rsp_new_vel_x;
   logic signed [COORD_BITS-1:0] rsp_new_vel_y;
   logic                         rsp_status;

   int unsigned error_count;
   int unsigned outstanding;
   int unsigned blocked_x_count;
   int unsigned blocked_y_count;
   int unsigned dropped_count;
   int unsigned beats_sent     = 0;
   int unsigned directed_beats = 0;
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   aabb_axis_blocking_mover_top #(
      .MAX_COLLIDERS(MAX_COLLIDERS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_entity_id    (req_entity_id),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_vel_x        (req_vel_x),
      .req_vel_y        (req_vel_y),
      .req_size_w       (req_size_w),
      .req_size_h       (req_size_h),
      .req_has_size     (req_has_size),
      .req_is_collidable(req_is_collidable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_pos_x    (rsp_new_pos_x),
      .rsp_new_pos_y    (rsp_new_pos_y),
      .rsp_new_vel_x    (rsp_new_vel_x),
      .rsp_new_vel_y    (rsp_new_vel_y),
      .rsp_status       (rsp_status)
   );

   amv_mover_checker #(
      .MAX_COLLIDERS(MAX_COLLIDERS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_entity_id    (req_entity_id),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_vel_x        (req_vel_x),
      .req_vel_y        (req_vel_y),
      .req_size_w       (req_size_w),
      .req_size_h       (req_size_h),
      .req_has_size     (req_has_size),
      .req_is_collidable(req_is_collidable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_pos_x    (rsp_new_pos_x),
      .rsp_new_pos_y    (rsp_new_pos_y),
      .rsp_new_vel_x    (rsp_new_vel_x),
      .rsp_new_vel_y    (rsp_new_vel_y),
      .rsp_status       (rsp_status),
      .error_count      (error_count),
      .outstanding      (outstanding),
      .blocked_x_count  (blocked_x_count),
      .blocked_y_count  (blocked_y_count),
      .dropped_count    (dropped_count)
   );

   initial begin
      #(20 * CYCLE_LIMIT);
      $display("[aabb_axis_blocking_mover_top] ERROR");
      $finish;
   end

   task automatic send_beat(
      input cmd_type               cmd,
      input logic [ID_BITS-1:0]    id,
      input logic [COORD_BITS-1:0] px, py, vx, vy,
      input logic [SIZE_BITS-1:0]  w, h,
      input logic                  has_size, collidable
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= cmd;
      req_entity_id     <= id;
      req_pos_x         <= px;
      req_pos_y         <= py;
      req_vel_x         <= vx;
      req_vel_y         <= vy;
      req_size_w        <= w;
      req_size_h        <= h;
      req_has_size      <= has_size;
      req_is_collidable <= collidable;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   function automatic logic [COORD_BITS-1:0] near(
      input logic [COORD_BITS-1:0] center,
      input int                    span
   );
      int off;
      off = int'($urandom_range(2 * span));
      return center + COORD_BITS'(off - span);
   endfunction

   // one scene: optional clear, a batch of boxes, then moves among them
   task automatic run_scene();
      logic [ID_BITS-1:0]    ids[$];
      logic [ID_BITS-1:0]    id;
      logic [COORD_BITS-1:0] center;
      int                    span;
      int                    n_boxes;
      int                    n_moves;
      int                    k;
      center = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
      span = ($urandom_range(4) == 0) ? 2000 : 150;
      if ($urandom_range(3) != 0)
         send_beat(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 15'($urandom), 15'($urandom),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      n_boxes = int'($urandom_range(MAX_COLLIDERS + 2));
      for (k = 0; k < n_boxes; k++) begin
         id = (ids.size() != 0 && $urandom_range(4) == 0) ?
              ids[$urandom_range(ids.size() - 1)] : 16'($urandom);
         ids.push_back(id);
         send_beat(CMD_ADD, id, near(center, span), near(center, span),
                   16'($urandom), 16'($urandom),
                   15'($urandom_range(120)), 15'($urandom_range(120)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      n_moves = int'($urandom_range(1, 14));
      for (k = 0; k < n_moves; k++) begin
         if ($urandom_range(7) == 0) begin
            send_beat(cmd_type'($urandom_range(3)), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom),
                      15'($urandom), 15'($urandom),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            id = (ids.size() != 0 && $urandom_range(2) == 0) ?
                 ids[$urandom_range(ids.size() - 1)] : 16'($urandom);
            send_beat(CMD_MOVE, id, near(center, span), near(center, span),
                      ($urandom_range(9) == 0) ? 16'($urandom) : near(16'd0, 60),
                      ($urandom_range(9) == 0) ? 16'($urandom) : near(16'd0, 60),
                      15'($urandom_range(80)), 15'($urandom_range(80)),
                      $urandom_range(9) != 0, $urandom_range(6) != 0);
         end
      end
   endtask

   initial begin
      int phase;
      int unsigned target;
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(CMD_NOP, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                15'h7FFF, 15'h7FFF, 1'b1, 1'b1);
      send_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      send_beat(CMD_ADD, 16'd10, 0, 0, 0, 0, 10, 10, 1'b1, 1'b1);
      send_beat(CMD_ADD, 16'hFFFF, 16'h7FFF, 16'h7FFF, 0, 0, 15'h7FFF, 15'h7FFF, 1'b0, 1'b0);
      send_beat(CMD_ADD, 16'd0, 16'h8000, 16'h8000, 0, 0, 0, 0, 1'b1, 1'b0);
      // duplicate id lands in a slot of its own
      send_beat(CMD_ADD, 16'd10, 100, 100, 0, 0, 20, 20, 1'b1, 1'b1);
      for (k = 4; k < MAX_COLLIDERS; k++)
         send_beat(CMD_ADD, 16'(200 + k), 16'(-1000 * k), 16'(1000 * k), 0, 0, 50, 50,
                   1'b1, 1'b1);
      // table full: add dropped
      send_beat(CMD_ADD, 16'd77, 0, 0, 0, 0, 5, 5, 1'b1, 1'b1);
      send_beat(CMD_MOVE, 16'd7, 2, 12, 0, 16'(-5), 4, 4, 1'b1, 1'b1);
      send_beat(CMD_MOVE, 16'd7, 16'(-6), 2, 5, 0, 4, 4, 1'b1, 1'b1);
      send_beat(CMD_MOVE, 16'd7, 16'(-5), 16'(-5), 1, 1, 20, 20, 1'b1, 1'b1);
      // edges touching only: not blocked
      send_beat(CMD_MOVE, 16'd7, 10, 0, 0, 1, 4, 4, 1'b1, 1'b1);
      // own id is skipped and both own boxes follow the move
      send_beat(CMD_MOVE, 16'd10, 2, 2, 3, 3, 4, 4, 1'b1, 1'b1);
      send_beat(CMD_MOVE, 16'd7, 16'(-20), 16'(-20), 1, 1, 15'h7FFF, 15'h7FFF, 1'b0, 1'b1);
      send_beat(CMD_MOVE, 16'd7, 2, 12, 0, 16'(-5), 4, 4, 1'b1, 1'b0);
      // blocked only when the sum is not wrapped
      send_beat(CMD_MOVE, 16'd7, 32760, 32767, 16'h7FFF, 16'h8000, 4, 4, 1'b1, 1'b1);
      send_beat(CMD_MOVE, 16'd7, 16'h7FFF, 16'h8000, 1, 16'(-1), 4, 4, 1'b1, 1'b0);
      directed_beats = beats_sent;

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         target = beats_sent + RANDOM_BEATS / 4;
         while (beats_sent < target) run_scene();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d command beats (%0d directed) under four idle/stall mixes.",
               beats_sent, directed_beats);
      $display("Moves blocked in x: %0d, in y: %0d; adds dropped on a full table: %0d.",
               blocked_x_count, blocked_y_count, dropped_count);
      if (error_count == 0) begin
         $display("[aabb_axis_blocking_mover_top] OK");
      end else begin
         $display("[aabb_axis_blocking_mover_top] ERROR");
      end
      $finish;
   end

endmodule
